/* hdl/tama_pkg.sv */
// Shared constants, payload types and state codes of the three-axis moving-average unit.
// Every other file in this folder but tama_ram refers to it by scoped names; it depends on nothing.
package tama_pkg;

	// Sample geometry and history depth
	localparam int DataW      = 32;
	localparam int WindowMax  = 64;
	localparam int CfgW       = 7;
	localparam int WindowRst  = 8;
	localparam int SlotW      = $clog2(WindowMax);
	localparam int CntW       = $clog2(WindowMax + 1);
	localparam int SumW       = DataW + SlotW;
	localparam int DivCntW    = $clog2(SumW);
	localparam int RemW       = CntW + 1;
	localparam int Axes       = 3;
	localparam int HistW      = Axes * DataW;

	// Stream widths: payload packed from the lowest bit, padded to whole bytes
	localparam int InTdataW   = ((Axes * DataW + 7) / 8) * 8;
	localparam int InTuserW   = 1;
	localparam int OutTdataW  = ((Axes * DataW + CntW + 7) / 8) * 8;

	// Input queue between the front and the back
	localparam int QueueDepth = 2;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

	// One classified input item
	typedef struct packed {
		logic                    start;
		logic signed [DataW-1:0] z;
		logic signed [DataW-1:0] y;
		logic signed [DataW-1:0] x;
	} item_t;

	// Sequencer states of the back end
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PREP = 6'b000010,
		ST_ACC  = 6'b000100,
		ST_DIVI = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

endpackage

/* hdl/tama_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Stands alone; width and depth come from its parameters.
module tama_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/tama_front.sv */
// Front end: accepts input requests, unpacks them into items and holds them in a short queue.
// Depends on tama_pkg.
module tama_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tama_pkg::InTdataW-1:0]   in_data,
	input  logic [tama_pkg::InTuserW-1:0]   in_user,
	output logic                            q_valid,
	output tama_pkg::item_t                 q_item,
	input  logic                            q_pop
);

	tama_pkg::item_t                 entry_q [tama_pkg::QueueDepth];
	tama_pkg::item_t                 in_item;
	logic [tama_pkg::QPtrW-1:0]      wr_ptr_q;
	logic [tama_pkg::QPtrW-1:0]      rd_ptr_q;
	logic [tama_pkg::QCntW-1:0]      count_q;
	logic                            push;
	logic                            pop;

	// Unpack the request into its fields
	always_comb begin
		in_item.x     = in_data[0 +: tama_pkg::DataW];
		in_item.y     = in_data[tama_pkg::DataW +: tama_pkg::DataW];
		in_item.z     = in_data[2 * tama_pkg::DataW +: tama_pkg::DataW];
		in_item.start = in_user[0];
	end

	assign in_ready = (count_q != tama_pkg::QCntW'(tama_pkg::QueueDepth));
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;
	assign q_valid  = (count_q != '0);
	assign q_item   = entry_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	// Queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == tama_pkg::QPtrW'(tama_pkg::QueueDepth - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == tama_pkg::QPtrW'(tama_pkg::QueueDepth - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/tama_back.sv */
// Back end: history memory, running sums, bit-serial divider and output register.
// Depends on tama_pkg and tama_ram.
module tama_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [tama_pkg::CfgW-1:0]        window_length,
	input  logic                             q_valid,
	input  tama_pkg::item_t                  q_item,
	output logic                             q_pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tama_pkg::OutTdataW-1:0]   out_data
);

	tama_pkg::state_t                         state_q;
	tama_pkg::item_t                          item_q;
	logic [tama_pkg::CntW-1:0]                win_q;
	logic [tama_pkg::CntW-1:0]                fill_q;
	logic [tama_pkg::SlotW-1:0]               oldest_q;
	logic                                     drop_q;
	logic signed [tama_pkg::SumW-1:0]         sum_q [tama_pkg::Axes];
	logic [tama_pkg::SumW-1:0]                quo_q [tama_pkg::Axes];
	logic [tama_pkg::CntW-1:0]                rem_q [tama_pkg::Axes];
	logic                                     neg_q [tama_pkg::Axes];
	logic [tama_pkg::DivCntW-1:0]             div_cnt_q;
	logic                                     out_valid_q;
	logic [tama_pkg::DataW-1:0]               avg_q [tama_pkg::Axes];
	logic [tama_pkg::CntW-1:0]                held_q;

	logic [tama_pkg::CntW-1:0]                eff_win;
	logic                                     ram_we;
	logic                                     ram_re;
	logic [tama_pkg::SlotW-1:0]               wr_slot;
	logic [tama_pkg::HistW-1:0]               ram_wdata;
	logic [tama_pkg::HistW-1:0]               ram_rdata;
	logic [tama_pkg::SlotW:0]                 oldest_inc;
	logic [tama_pkg::SlotW-1:0]               oldest_nx;
	logic [tama_pkg::CntW-1:0]                fill_mid;
	logic [tama_pkg::SlotW:0]                 slot_sum;
	logic signed [tama_pkg::DataW-1:0]        new_smp [tama_pkg::Axes];
	logic signed [tama_pkg::SumW-1:0]         old_ext [tama_pkg::Axes];
	logic signed [tama_pkg::SumW-1:0]         acc_sum [tama_pkg::Axes];
	logic [tama_pkg::RemW-1:0]                rem_sh [tama_pkg::Axes];
	logic                                     rem_ge [tama_pkg::Axes];
	logic [tama_pkg::RemW-1:0]                rem_dif [tama_pkg::Axes];
	logic [tama_pkg::DataW-1:0]               avg_nx [tama_pkg::Axes];
	logic                                     out_load;

	// Effective window: zero acts as one, large values saturate
	always_comb begin
		if (window_length == '0) begin
			eff_win = tama_pkg::CntW'(1);
		end else if (int'(window_length) > tama_pkg::WindowMax) begin
			eff_win = tama_pkg::CntW'(tama_pkg::WindowMax);
		end else begin
			eff_win = tama_pkg::CntW'(window_length);
		end
	end

	// Slot bookkeeping for the accumulate step
	always_comb begin
		oldest_inc = {1'b0, oldest_q} + 1'b1;
		if (!drop_q) begin
			oldest_nx = oldest_q;
		end else if (oldest_inc >= (tama_pkg::SlotW + 1)'(tama_pkg::WindowMax)) begin
			oldest_nx = tama_pkg::SlotW'(oldest_inc - (tama_pkg::SlotW + 1)'(tama_pkg::WindowMax));
		end else begin
			oldest_nx = oldest_inc[tama_pkg::SlotW-1:0];
		end
		fill_mid = drop_q ? fill_q - 1'b1 : fill_q;
		slot_sum = {1'b0, oldest_nx} + (tama_pkg::SlotW + 1)'(fill_mid);
		if (slot_sum >= (tama_pkg::SlotW + 1)'(tama_pkg::WindowMax)) begin
			wr_slot = tama_pkg::SlotW'(slot_sum - (tama_pkg::SlotW + 1)'(tama_pkg::WindowMax));
		end else begin
			wr_slot = slot_sum[tama_pkg::SlotW-1:0];
		end
	end

	// Per-axis sum update and one restoring divide step
	always_comb begin
		new_smp[0] = item_q.x;
		new_smp[1] = item_q.y;
		new_smp[2] = item_q.z;
		for (int a = 0; a < tama_pkg::Axes; a++) begin
			old_ext[a] = drop_q ?
				tama_pkg::SumW'(signed'(ram_rdata[a * tama_pkg::DataW +: tama_pkg::DataW])) : '0;
			acc_sum[a] = sum_q[a] - old_ext[a] + tama_pkg::SumW'(new_smp[a]);
			rem_sh[a]  = {rem_q[a], quo_q[a][tama_pkg::SumW-1]};
			rem_ge[a]  = (rem_sh[a] >= tama_pkg::RemW'(fill_q));
			rem_dif[a] = rem_sh[a] - tama_pkg::RemW'(fill_q);
			avg_nx[a]  = neg_q[a] ? -quo_q[a][tama_pkg::DataW-1:0] : quo_q[a][tama_pkg::DataW-1:0];
		end
	end

	assign ram_we    = (state_q == tama_pkg::ST_ACC);
	assign ram_re    = (state_q == tama_pkg::ST_PREP);
	assign ram_wdata = {item_q.z, item_q.y, item_q.x};
	assign q_pop     = (state_q == tama_pkg::ST_IDLE) && q_valid;
	assign out_load  = (state_q == tama_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// History store for all three axes side by side
	tama_ram #(
		.WIDTH (tama_pkg::HistW),
		.DEPTH (tama_pkg::WindowMax)
	) u_hist (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (wr_slot),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (oldest_q),
		.rd_data (ram_rdata)
	);

	// Item payload and divider datapath
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
			win_q  <= eff_win;
		end
		for (int a = 0; a < tama_pkg::Axes; a++) begin
			if (state_q == tama_pkg::ST_DIVI) begin
				neg_q[a] <= sum_q[a][tama_pkg::SumW-1];
				quo_q[a] <= sum_q[a][tama_pkg::SumW-1] ? -sum_q[a] : sum_q[a];
				rem_q[a] <= '0;
			end else if (state_q == tama_pkg::ST_DIV) begin
				rem_q[a] <= rem_ge[a] ? tama_pkg::CntW'(rem_dif[a]) : tama_pkg::CntW'(rem_sh[a]);
				quo_q[a] <= {quo_q[a][tama_pkg::SumW-2:0], rem_ge[a]};
			end
		end
		if (out_load) begin
			avg_q  <= avg_nx;
			held_q <= fill_q;
		end
	end

	// Sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tama_pkg::ST_IDLE;
			fill_q      <= '0;
			oldest_q    <= '0;
			drop_q      <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			for (int a = 0; a < tama_pkg::Axes; a++) begin
				sum_q[a] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				tama_pkg::ST_IDLE: begin
					if (q_valid) begin
						if (q_item.start) begin
							fill_q   <= '0;
							oldest_q <= '0;
							for (int a = 0; a < tama_pkg::Axes; a++) begin
								sum_q[a] <= '0;
							end
						end
						state_q <= tama_pkg::ST_PREP;
					end
				end
				tama_pkg::ST_PREP: begin
					drop_q  <= (fill_q >= win_q);
					state_q <= tama_pkg::ST_ACC;
				end
				tama_pkg::ST_ACC: begin
					for (int a = 0; a < tama_pkg::Axes; a++) begin
						sum_q[a] <= acc_sum[a];
					end
					oldest_q <= oldest_nx;
					fill_q   <= fill_mid + 1'b1;
					state_q  <= tama_pkg::ST_DIVI;
				end
				tama_pkg::ST_DIVI: begin
					div_cnt_q <= tama_pkg::DivCntW'(tama_pkg::SumW - 1);
					state_q   <= tama_pkg::ST_DIV;
				end
				tama_pkg::ST_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= tama_pkg::ST_DONE;
					end else begin
						div_cnt_q <= div_cnt_q - 1'b1;
					end
				end
				tama_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= tama_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tama_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = tama_pkg::OutTdataW'({held_q, avg_q[2], avg_q[1], avg_q[0]});

	// The count never passes the history depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= tama_pkg::CntW'(tama_pkg::WindowMax))
		else $error("fill count beyond history depth");

	// The oldest slot always addresses a real entry
	a_oldest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oldest_q < tama_pkg::SlotW'(tama_pkg::WindowMax - 1) ||
		oldest_q == tama_pkg::SlotW'(tama_pkg::WindowMax - 1))
		else $error("oldest slot out of range");

	// After accumulating, at least the new sample is held
	a_fill_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tama_pkg::ST_ACC |=> fill_q != '0)
		else $error("empty history after accumulate");

	// A result on offer always covers at least one sample
	a_held_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> held_q != '0)
		else $error("result with zero samples");

endmodule

/* hdl/three_axis_moving_average_unit.sv */
// Three-axis boxcar moving-average unit, top level.
// Depends on tama_pkg, tama_front, tama_back and tama_ram.
//
// Input stream (s_axis_*): one request per position sample; tdata carries x, y and z in
// signed Q16.16, tuser[0] starts a new trajectory and empties the history first.
// Output stream (m_axis_*): one request per input sample carrying the per-axis averages,
// truncated toward zero, and the number of samples they cover.
// cfg_wr_en/cfg_wr_data write the window length (0 acts as 1, above 64 acts as 64); write
// it only while no sample is in flight.
// The back end takes one sample at a time; its 38-step restoring divider (one quotient bit
// per cycle, three axes in parallel) dominates. A sample passes the queue and the states
// idle, prep, acc, divide set-up, divide and done before its result reaches m_axis_tvalid.
// A two-entry queue takes further samples while the back end is busy; s_axis_tready
// falls once it is full.
// When the receiver stalls, the result waits in the output register and the back end
// holds its next finished result until the register frees; the queue still fills.
// After reset the history is empty, the window is 8 and no result is pending; the
// history memory needs no clearing pass since only written entries are read.
module three_axis_moving_average_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [tama_pkg::InTdataW-1:0]      s_axis_tdata,  // pos_x, pos_y, pos_z
	input  logic [tama_pkg::InTuserW-1:0]      s_axis_tuser,  // trajectory_start
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [tama_pkg::OutTdataW-1:0]     m_axis_tdata,  // avg_x, avg_y, avg_z, samples_held, pad
	input  logic                               cfg_wr_en,
	input  logic [tama_pkg::CfgW-1:0]          cfg_wr_data
);

	logic [tama_pkg::CfgW-1:0] window_length_q;
	logic                      q_valid;
	logic                      q_pop;
	tama_pkg::item_t           q_item;

	// Window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= tama_pkg::CfgW'(tama_pkg::WindowRst);
		end else if (cfg_wr_en) begin
			window_length_q <= cfg_wr_data;
		end
	end

	// Accepting front end with its queue
	tama_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// Filtering back end
	tama_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.window_length (window_length_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_data      (m_axis_tdata)
	);

endmodule
